// ===== hdl/http_chunked_body_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_assert.svh
// Assertion macros for the chunked body decoder; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

`ifndef SYNTH
// checked only while out of reset
`define HCBD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked on every edge, reset included
`define HCBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HCBD_ASSERT(lbl, clk, rstn, prop, msg)
`define HCBD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/hcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, character codes and the hex digit decoder of the chunked decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_END      = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_e;

  // decoder phases, one-hot
  typedef enum logic [6:0] {
    PH_LINE    = 7'b0000001,
    PH_LINE_CR = 7'b0000010,
    PH_DATA    = 7'b0000100,
    PH_TRAIL   = 7'b0001000,
    PH_FINAL   = 7'b0010000,
    PH_DONE    = 7'b0100000,
    PH_HALT    = 7'b1000000
  } phase_e;

  // character codes
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF_HX = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;

  // bytes dropped after a chunk or after the zero size line
  localparam logic [1:0] TRAIL_BYTES = 2'd2;

  typedef struct packed {
    logic       action;
    logic [7:0] body_byte;
  } item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload_byte;
    logic       chunk_last;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // decode one ascii hex digit
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if (c >= CHAR_LA && c <= CHAR_LF_HX) begin
      h.ok  = 1'b1;
      h.val = 4'(c - CHAR_LA + 8'd10);
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      h.ok  = 1'b1;
      h.val = 4'(c - CHAR_UA + 8'd10);
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/hcbd_in_stage.sv =====
// ----------------------------------------------------------------------------
// hcbd_in_stage
// Input register: holds one accepted item until the engine takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire hcbd_pkg::item_t item_i,
  input  wire logic           take_i,
  output logic                valid_o,
  output hcbd_pkg::item_t     item_o
);
  import hcbd_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // free when empty or when the held item leaves this cycle
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== hdl/hcbd_engine.sv =====
// ----------------------------------------------------------------------------
// hcbd_engine
// Decoder state and the combinational step that maps one item to its result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "http_chunked_body_decoder_assert.svh"

module hcbd_engine #(
  parameter int unsigned SIZE_BITS      = 32,
  parameter int unsigned MAX_LINE_CHARS = 31
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire hcbd_pkg::item_t item_i,
  output logic                 emit_o,
  output hcbd_pkg::result_t    res_o
);
  import hcbd_pkg::*;

  localparam int unsigned LcW = $clog2(MAX_LINE_CHARS + 1);

  phase_e               phase_q, phase_d;
  logic [SIZE_BITS-1:0] size_q, size_d;
  logic [SIZE_BITS-1:0] left_q, left_d;
  logic [SIZE_BITS-1:0] left_dec;
  logic [LcW-1:0]       chars_q, chars_d;
  logic [LcW-1:0]       chars_inc;
  logic                 stopped_q, stopped_d;
  logic [1:0]           skip_q, skip_d;
  logic [1:0]           skip_dec;
  hex_t                 hex;
  logic                 line_end;
  logic                 ovf;

  assign hex       = hex_decode(item_i.body_byte);
  assign chars_inc = chars_q + LcW'(1);
  assign left_dec  = (left_q != '0) ? left_q - SIZE_BITS'(1) : left_q;
  assign skip_dec  = (skip_q != '0) ? skip_q - 2'd1 : skip_q;

  // next state and result for the item in the input register
  always_comb begin
    phase_d   = phase_q;
    size_d    = size_q;
    left_d    = left_q;
    chars_d   = chars_q;
    stopped_d = stopped_q;
    skip_d    = skip_q;
    emit_o    = 1'b0;
    res_o     = '{kind: KIND_PAYLOAD, payload_byte: 8'd0, chunk_last: 1'b0};
    line_end  = 1'b0;
    ovf       = 1'b0;

    if (item_i.action) begin
      // start a new body
      phase_d   = PH_LINE;
      size_d    = '0;
      left_d    = '0;
      chars_d   = '0;
      stopped_d = 1'b0;
      skip_d    = '0;
    end else begin
      unique case (phase_q)
        PH_LINE: begin
          if (item_i.body_byte == CHAR_CR) begin
            phase_d = PH_LINE_CR;
          end else begin
            if (!stopped_q) begin
              if (!hex.ok) begin
                stopped_d = 1'b1;
              end else if (size_q[SIZE_BITS-1 -: 4] != 4'd0) begin
                ovf          = 1'b1;
                phase_d      = PH_HALT;
                emit_o       = 1'b1;
                res_o.kind   = KIND_OVERFLOW;
              end else begin
                size_d = {size_q[SIZE_BITS-5:0], hex.val};
              end
            end
            if (!ovf) begin
              chars_d = chars_inc;
              // long size line ends on its own
              if (chars_inc >= LcW'(MAX_LINE_CHARS)) begin
                line_end = 1'b1;
              end
            end
          end
        end
        PH_LINE_CR: begin
          if (item_i.body_byte == CHAR_LF) begin
            line_end = 1'b1;
          end else begin
            phase_d = PH_LINE;
          end
        end
        PH_DATA: begin
          left_d             = left_dec;
          emit_o             = 1'b1;
          res_o.kind         = KIND_PAYLOAD;
          res_o.payload_byte = item_i.body_byte;
          if (left_dec == '0) begin
            res_o.chunk_last = 1'b1;
            phase_d          = PH_TRAIL;
            skip_d           = TRAIL_BYTES;
          end
        end
        PH_TRAIL: begin
          skip_d = skip_dec;
          if (skip_dec == '0) begin
            size_d    = '0;
            chars_d   = '0;
            stopped_d = 1'b0;
            phase_d   = PH_LINE;
          end
        end
        PH_FINAL: begin
          skip_d = skip_dec;
          if (skip_dec == '0) begin
            phase_d    = PH_DONE;
            emit_o     = 1'b1;
            res_o.kind = KIND_END;
          end
        end
        default: begin
          // done or halted: bytes are ignored
        end
      endcase

      // size line complete: zero ends the body, else a chunk follows
      if (line_end) begin
        if (size_d == '0) begin
          phase_d = PH_FINAL;
          skip_d  = TRAIL_BYTES;
        end else begin
          left_d  = size_d;
          phase_d = PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LINE;
      size_q    <= '0;
      left_q    <= '0;
      chars_q   <= '0;
      stopped_q <= 1'b0;
      skip_q    <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      size_q    <= size_d;
      left_q    <= left_d;
      chars_q   <= chars_d;
      stopped_q <= stopped_d;
      skip_q    <= skip_d;
    end
  end

  // checks
  `HCBD_ASSERT_ALWAYS(a_reset_phase, clk_i, !rst_ni |-> (phase_q == PH_LINE),
    "phase not at size line during reset")
  `HCBD_ASSERT(a_data_nonzero, clk_i, rst_ni, (phase_q == PH_DATA) |-> (left_q != '0),
    "in data phase with no bytes left")
  `HCBD_ASSERT(a_last_to_trail, clk_i, rst_ni,
    (step_i && !item_i.action && phase_q == PH_DATA && left_q == SIZE_BITS'(1))
      |=> (phase_q == PH_TRAIL),
    "last chunk byte did not move to trailer")
  `HCBD_ASSERT(a_ovf_halts, clk_i, rst_ni,
    (step_i && emit_o && res_o.kind == KIND_OVERFLOW) |=> (phase_q == PH_HALT),
    "overflow did not halt the decoder")
  `HCBD_ASSERT(a_action_clears, clk_i, rst_ni,
    (step_i && item_i.action) |=> (phase_q == PH_LINE && size_q == '0 && chars_q == '0),
    "new body did not clear the size line")

endmodule

`default_nettype wire

// ===== hdl/hcbd_out_stage.sv =====
// ----------------------------------------------------------------------------
// hcbd_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire hcbd_pkg::result_t res_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output hcbd_pkg::result_t      res_o
);
  import hcbd_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // room for a new result when empty or draining this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== hdl/http_chunked_body_decoder.sv =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes an HTTP/1.1 chunked body, one byte per item.
//
// Input channel (in_valid_i/in_ready_o): action_i = 1 starts a new body,
// action_i = 0 feeds body_byte_i. Output channel (out_valid_o/out_ready_i):
// kind_o is payload, end of body or size overflow; payload_byte_o and
// chunk_last_o carry the decoded byte and the last-of-chunk mark.
// Size line bytes, trailing CR LF bytes after a chunk, the first trailing
// byte after the zero size line and bytes after the end or an overflow give
// no result. Throughput: one item per cycle while the receiver does not
// stall, set by the combinational decode step between the two registers.
// The result register loads at the edge where the item leaves the input
// register, and out_valid_o then rises; the receiver takes the result from
// the result register.
// Reset clears both registers and puts the decoder at the start of a size
// line. While the receiver stalls with a result pending, an item that gives
// a result waits in the input register and in_ready_o falls; items that give
// no result still pass.
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder #(
  parameter int unsigned SIZE_BITS      = 32,
  parameter int unsigned MAX_LINE_CHARS = 31
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       action_i,
  input  wire logic [7:0] body_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      payload_byte_o,
  output logic            chunk_last_o
);
  import hcbd_pkg::*;

  item_t   in_item;
  item_t   cur_item;
  logic    cur_valid;
  logic    emit;
  result_t step_res;
  result_t out_res;
  logic    out_free;
  logic    fire;

  assign in_item = '{action: action_i, body_byte: body_byte_i};

  // the held item moves on unless its result has nowhere to go
  assign fire = cur_valid && (!emit || out_free);

  hcbd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .take_i     (fire),
    .valid_o    (cur_valid),
    .item_o     (cur_item)
  );

  hcbd_engine #(
    .SIZE_BITS      (SIZE_BITS),
    .MAX_LINE_CHARS (MAX_LINE_CHARS)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .item_i (cur_item),
    .emit_o (emit),
    .res_o  (step_res)
  );

  hcbd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && emit),
    .res_i       (step_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  // result fields
  assign kind_o         = out_res.kind;
  assign payload_byte_o = out_res.payload_byte;
  assign chunk_last_o   = out_res.chunk_last;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chunked body decoder. A short table of directed
// items covers the corner cases of the size line, the chunk data, the trailing
// bytes, the end of the body and the size overflow. Random bodies follow,
// most of them well formed with random content, some of them noise. Every
// accepted item runs through a bench-side decoder, and each result is compared
// field by field with the oldest expected one. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbd_pkg::*;

  localparam int unsigned SIZE_W    = 32;
  localparam int unsigned MAX_LINE  = 31;
  localparam int unsigned N_ITEMS   = 1350;
  localparam int unsigned IDLE_STOP = 2000;

  typedef struct packed {
    logic       action;
    logic [7:0] body;
    logic       typed;
    result_t    res;
  } row_t;

  localparam result_t NO_RES = '{KIND_PAYLOAD, 8'h00, 1'b0};

  // directed items; typed rows carry their own expected result
  localparam int unsigned N_ROWS = 27;
  localparam row_t DIRECTED [N_ROWS] = '{
    '{1'b1, 8'h00, 1'b0, NO_RES},                          // new body
    '{1'b0, "1",   1'b0, NO_RES},
    '{1'b0, CHAR_CR, 1'b0, NO_RES},
    '{1'b0, "X",   1'b0, NO_RES},                          // cr without lf
    '{1'b0, CHAR_CR, 1'b0, NO_RES},
    '{1'b0, CHAR_LF, 1'b0, NO_RES},
    '{1'b0, 8'h00, 1'b1, '{KIND_PAYLOAD, 8'h00, 1'b1}},    // single byte chunk
    '{1'b0, 8'hFF, 1'b0, NO_RES},                          // trailing bytes
    '{1'b0, 8'h80, 1'b0, NO_RES},
    '{1'b0, "0",   1'b0, NO_RES},                          // zero size, extension
    '{1'b0, ";",   1'b0, NO_RES},
    '{1'b0, CHAR_CR, 1'b0, NO_RES},
    '{1'b0, CHAR_LF, 1'b0, NO_RES},
    '{1'b0, CHAR_CR, 1'b0, NO_RES},
    '{1'b0, CHAR_LF, 1'b1, '{KIND_END, 8'h00, 1'b0}},
    '{1'b0, "A",   1'b0, NO_RES},                          // ignored after end
    '{1'b1, 8'hFF, 1'b0, NO_RES},
    '{1'b0, "f",   1'b0, NO_RES},                          // largest size
    '{1'b0, "F",   1'b0, NO_RES},
    '{1'b0, "F",   1'b0, NO_RES},
    '{1'b0, "F",   1'b0, NO_RES},
    '{1'b0, "F",   1'b0, NO_RES},
    '{1'b0, "F",   1'b0, NO_RES},
    '{1'b0, "F",   1'b0, NO_RES},
    '{1'b0, "F",   1'b0, NO_RES},
    '{1'b0, "a",   1'b1, '{KIND_OVERFLOW, 8'h00, 1'b0}},   // one digit too many
    '{1'b0, "7",   1'b0, NO_RES}                           // ignored while halted
  };

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b1;
  logic       in_valid_i  = 1'b0;
  logic       action_i    = 1'b0;
  logic [7:0] body_byte_i = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] kind_o;
  logic [7:0] payload_byte_o;
  logic       chunk_last_o;

  // bench-side decoder state
  phase_e      dec_phase = PH_LINE;
  logic [31:0] size_acc  = '0;
  logic [31:0] bytes_due = '0;
  logic [4:0]  line_len  = '0;
  logic        hex_off   = 1'b0;
  logic [1:0]  drop_left = '0;

  result_t     result_q [$];
  int unsigned sent_cnt  = 0;
  int unsigned err_cnt   = 0;
  int unsigned idle_cnt  = 0;
  bit          calm      = 1'b0;

  http_chunked_body_decoder #(
    .SIZE_BITS      (SIZE_W),
    .MAX_LINE_CHARS (MAX_LINE)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .body_byte_i    (body_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .chunk_last_o   (chunk_last_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // end of the size line: zero size ends the body, else chunk data follows
  function automatic void close_size_line();
    if (size_acc == 0) begin
      dec_phase = PH_FINAL;
      drop_left = TRAIL_BYTES;
    end else begin
      bytes_due = size_acc;
      dec_phase = PH_DATA;
    end
  endfunction

  // decode one item; returns 1 when it gives a result
  function automatic bit decode_item(input logic act, input logic [7:0] c,
                                     output result_t r);
    logic [3:0] nib;
    bit         is_hex;
    r      = NO_RES;
    nib    = '0;
    is_hex = 1'b0;
    if (act) begin
      dec_phase = PH_LINE;
      size_acc  = '0;
      bytes_due = '0;
      line_len  = '0;
      hex_off   = 1'b0;
      drop_left = '0;
      return 1'b0;
    end
    case (dec_phase)
      PH_LINE: begin
        if (c == CHAR_CR) begin
          dec_phase = PH_LINE_CR;
          return 1'b0;
        end
        if (!hex_off) begin
          if (c >= "0" && c <= "9") begin
            is_hex = 1'b1;
            nib    = 4'(c - "0");
          end else if (c >= "a" && c <= "f") begin
            is_hex = 1'b1;
            nib    = 4'(c - "a" + 8'd10);
          end else if (c >= "A" && c <= "F") begin
            is_hex = 1'b1;
            nib    = 4'(c - "A" + 8'd10);
          end
          if (!is_hex) begin
            hex_off = 1'b1;
          end else begin
            // next digit would not fit
            if (size_acc[SIZE_W-1 -: 4] != 0) begin
              dec_phase = PH_HALT;
              r.kind    = KIND_OVERFLOW;
              return 1'b1;
            end
            size_acc = {size_acc[SIZE_W-5:0], nib};
          end
        end
        line_len++;
        if (line_len >= MAX_LINE) close_size_line();
        return 1'b0;
      end
      PH_LINE_CR: begin
        if (c == CHAR_LF) close_size_line();
        else dec_phase = PH_LINE;
        return 1'b0;
      end
      PH_DATA: begin
        if (bytes_due > 0) bytes_due--;
        r.payload_byte = c;
        if (bytes_due == 0) begin
          dec_phase    = PH_TRAIL;
          drop_left    = TRAIL_BYTES;
          r.chunk_last = 1'b1;
        end
        return 1'b1;
      end
      PH_TRAIL: begin
        if (drop_left > 0) drop_left--;
        if (drop_left == 0) begin
          size_acc  = '0;
          line_len  = '0;
          hex_off   = 1'b0;
          dec_phase = PH_LINE;
        end
        return 1'b0;
      end
      PH_FINAL: begin
        if (drop_left > 0) drop_left--;
        if (drop_left == 0) begin
          dec_phase = PH_DONE;
          r.kind    = KIND_END;
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 10) return CHAR_ZERO + 8'(n);
    return (upper ? CHAR_UA : CHAR_LA) + 8'(n) - 8'd10;
  endfunction

  // send one item after a random gap, then predict its result
  task automatic send_item(input logic act, input logic [7:0] b, input bit typed,
                           input result_t typed_res);
    int unsigned gap;
    result_t     r;
    bit          has;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    body_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sent_cnt++;
    has = decode_item(act, b, r);
    if (typed) result_q.push_back(typed_res);
    else if (has) result_q.push_back(r);
  endtask

  task automatic feed(input logic act, input logic [7:0] b);
    send_item(act, b, 1'b0, NO_RES);
  endtask

  // hold the sender until every expected result has come
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (result_q.size() != 0);
  endtask

  // size line with optional leading zeros, extension and stray cr
  task automatic feed_size_line(input logic [31:0] sz, input bit empty);
    int unsigned ndig;
    int unsigned ext;
    if (!empty) begin
      ndig = 1;
      while (ndig < 8 && (sz >> (4 * ndig)) != 0) ndig++;
      repeat ($urandom_range(0, 2)) feed(1'b0, CHAR_ZERO);
      for (int i = ndig - 1; i >= 0; i--) begin
        feed(1'b0, hex_char(sz[4*i +: 4], 1'($urandom_range(0, 1))));
        // cr followed by a non-lf byte is dropped
        if ($urandom_range(0, 15) == 0) begin
          feed(1'b0, CHAR_CR);
          feed(1'b0, 8'($urandom_range(0, 255)) | 8'h80);
        end
      end
    end
    // chunk extension
    if ($urandom_range(0, 3) == 0) begin
      ext = $urandom_range(0, 5);
      feed(1'b0, ";");
      repeat (ext) feed(1'b0, 8'($urandom_range(8'h20, 8'h7E)));
    end
    feed(1'b0, CHAR_CR);
    feed(1'b0, CHAR_LF);
  endtask

  // trailing bytes, mostly cr lf
  task automatic feed_trail();
    if ($urandom_range(0, 4) == 0) begin
      repeat (2) feed(1'b0, 8'($urandom_range(0, 255)));
    end else begin
      feed(1'b0, CHAR_CR);
      feed(1'b0, CHAR_LF);
    end
  endtask

  // one random body, started by a clear
  task automatic run_body();
    int unsigned mode;
    int unsigned nchunk;
    logic [31:0] sz;
    calm = ($urandom_range(0, 4) == 0);
    feed(1'b1, 8'($urandom_range(0, 255)));
    mode = $urandom_range(0, 9);
    if (mode <= 6) begin
      // well-formed body
      nchunk = $urandom_range(1, 4);
      repeat (nchunk) begin
        sz = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200)
                                         : $urandom_range(1, 24);
        feed_size_line(sz, 1'b0);
        repeat (sz) feed(1'b0, 8'($urandom_range(0, 255)));
        feed_trail();
      end
      feed_size_line(32'd0, $urandom_range(0, 3) == 0);
      feed_trail();
      repeat ($urandom_range(0, 2)) feed(1'b0, 8'($urandom_range(0, 255)));
    end else if (mode == 7) begin
      // raw noise
      repeat ($urandom_range(5, 40)) feed(1'b0, 8'($urandom_range(0, 255)));
    end else if (mode == 8) begin
      // size line near or beyond the length limit
      repeat ($urandom_range(MAX_LINE - 3, MAX_LINE + 9))
        feed(1'b0, 8'($urandom_range(8'h20, 8'h7E)));
      repeat ($urandom_range(0, 30)) feed(1'b0, 8'($urandom_range(0, 255)));
    end else begin
      // oversized chunk size
      feed(1'b0, hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1))));
      repeat ($urandom_range(8, 11))
        feed(1'b0, hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      repeat ($urandom_range(0, 3)) feed(1'b0, 8'($urandom_range(0, 255)));
    end
  endtask

  // receiver with random stalls
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        $error("unexpected result: kind %0d byte %02h last %0b",
               kind_o, payload_byte_o, chunk_last_o);
        err_cnt++;
      end else begin
        exp_res = result_q.pop_front();
        if (kind_o !== exp_res.kind) begin
          $error("kind: expected %0d, got %0d", exp_res.kind, kind_o);
          err_cnt++;
        end
        if (payload_byte_o !== exp_res.payload_byte) begin
          $error("payload_byte: expected %02h, got %02h",
                 exp_res.payload_byte, payload_byte_o);
          err_cnt++;
        end
        if (chunk_last_o !== exp_res.chunk_last) begin
          $error("chunk_last: expected %0b, got %0b",
                 exp_res.chunk_last, chunk_last_o);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any item moving
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cnt = 0;
    end else begin
      idle_cnt++;
      if (idle_cnt >= IDLE_STOP) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    bit paused;
    paused = 1'b0;
    // falling edge once every process waits on it
    rst_ni <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < N_ROWS; i++)
      send_item(DIRECTED[i].action, DIRECTED[i].body, DIRECTED[i].typed,
                DIRECTED[i].res);
    drain_results();

    // random bodies, with one full drain halfway
    while (sent_cnt < N_ITEMS) begin
      run_body();
      if (!paused && sent_cnt >= N_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
